FILE: design/pclb_pkg.sv
// Shared types and codes for the particle cell list builder.
package pclb_pkg;

    // Input item function codes
    localparam logic [1:0] FN_CLEAR   = 2'd0;
    localparam logic [1:0] FN_INSERT  = 2'd1;
    localparam logic [1:0] FN_QBUCKET = 2'd2;
    localparam logic [1:0] FN_QLINK   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_OUTSIDE  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_QDONE    = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_X = 3'd0;
    localparam logic [2:0] CFG_MAX_X = 3'd1;
    localparam logic [2:0] CFG_MIN_Y = 3'd2;
    localparam logic [2:0] CFG_MAX_Y = 3'd3;
    localparam logic [2:0] CFG_INV   = 3'd4;
    localparam logic [2:0] CFG_BPR   = 3'd5;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        particle_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [11:0]        query_bucket;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] bucket_id;
        logic [11:0] prev_particle;
        logic        prev_valid;
        logic [11:0] first_particle;
        logic        first_valid;
        logic [11:0] last_particle;
        logic        last_valid;
        logic [11:0] next_particle;
        logic        next_valid;
    } t_result;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic [31:0]        inv_len;
        logic [12:0]        bpr;
    } t_cfg;

    // One table entry: valid flag plus particle index
    typedef struct packed {
        logic        valid;
        logic [11:0] idx;
    } t_entry;

    typedef struct packed {
        logic done;
        logic outside;
        logic overflow;
    } t_calc_flags;

endpackage

FILE: design/particle_cell_list_builder_core.sv
// Top level of the 2D cell linked list builder: tables, sequencer, ports.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall   | t_item: func, ids, position
//  out     | output    | o_out_valid/i_out_stall | t_result: status and links
//  cfg     | input     | i_cfg_valid/o_cfg_ready | register index, 32-bit data
//
// One word is worked on at a time. A query goes from accept through S_RD and
// S_RMW to the output register; an insert first passes the bucket index
// pipeline, then a read and a read-modify-write of the last-entry table. A clear
// walks every entry of the tables.
// After reset the same clearing pass runs with o_in_stall high and no result.
// The output register lets the next word start while a result waits on
// i_out_stall.
module particle_cell_list_builder_core #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_BUCKETS   = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pclb_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pclb_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import pclb_pkg::*;

    localparam int BAW       = $clog2(MAX_BUCKETS);
    localparam int PAW       = $clog2(MAX_PARTICLES);
    localparam int CLR_DEPTH = (MAX_BUCKETS > MAX_PARTICLES) ? MAX_BUCKETS : MAX_PARTICLES;
    localparam int CW        = $clog2(CLR_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_RMW  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_clr_cnt;
    logic          r_clr_report;
    logic          r_calc_go;
    t_item         r_item;
    t_cfg          r_cfg;
    logic [BAW-1:0] r_bkt;
    t_result       r_res, n_res;
    logic          r_out_valid;
    t_result       r_out;

    t_calc_flags    calc_flags;
    logic [BAW-1:0] calc_bucket;

    logic accept, pid_ok, qb_ok, out_free, clr_last;

    // memories
    t_entry mem_first [MAX_BUCKETS];
    t_entry mem_last  [MAX_BUCKETS];
    t_entry mem_next  [MAX_PARTICLES];
    t_entry r_first_rd, r_last_rd, r_next_rd;

    logic           first_we, last_we, next_we;
    logic [BAW-1:0] first_waddr, last_waddr, bkt_raddr;
    logic [PAW-1:0] next_waddr, next_raddr;
    t_entry         first_wdata, last_wdata, next_wdata, new_entry;

    assign accept   = i_in_valid && !o_in_stall;
    assign pid_ok   = int'(r_item.particle_id) < MAX_PARTICLES;
    assign qb_ok    = int'(r_item.query_bucket) < MAX_BUCKETS;
    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = r_clr_cnt == CW'(CLR_DEPTH - 1);

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x   <= 32'sd0;
            r_cfg.max_x   <= 32'sh7FFF_FFFF;
            r_cfg.min_y   <= 32'sd0;
            r_cfg.max_y   <= 32'sh7FFF_FFFF;
            r_cfg.inv_len <= 32'd65536;
            r_cfg.bpr     <= 13'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_X: r_cfg.min_x   <= i_cfg_data;
                CFG_MAX_X: r_cfg.max_x   <= i_cfg_data;
                CFG_MIN_Y: r_cfg.min_y   <= i_cfg_data;
                CFG_MAX_Y: r_cfg.max_y   <= i_cfg_data;
                CFG_INV:   r_cfg.inv_len <= i_cfg_data;
                CFG_BPR:   r_cfg.bpr     <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    pclb_cell_calc #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .BW          (BAW)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_calc_go),
        .i_pos_x  (r_item.pos_x),
        .i_pos_y  (r_item.pos_y),
        .i_cfg    (r_cfg),
        .o_flags  (calc_flags),
        .o_bucket (calc_bucket)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.func)
                        FN_CLEAR:  n_state = S_CLR;
                        FN_INSERT: n_state = S_CALC;
                        default:   n_state = S_RD;
                    endcase
                end
            end
            S_CLR: begin
                if (clr_last) n_state = r_clr_report ? S_OUT : S_IDLE;
            end
            S_CALC: begin
                if (calc_flags.done) begin
                    if (calc_flags.outside || calc_flags.overflow || !pid_ok) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:  n_state = S_RMW;
            S_RMW: n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_cnt    <= '0;
            r_clr_report <= 1'b0;
            r_calc_go    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_calc_go <= accept && (i_in_data.func == FN_INSERT);
            if (r_state == S_CLR) begin
                r_clr_cnt <= clr_last ? '0 : r_clr_cnt + CW'(1);
            end
            if (accept) r_clr_report <= 1'b1;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word being built
    always_comb begin
        n_res = r_res;
        case (r_state)
            S_CLR: begin
                n_res        = '0;
                n_res.status = ST_CLEARED;
            end
            S_CALC: begin
                n_res = '0;
                if (calc_flags.outside) begin
                    n_res.status = ST_OUTSIDE;
                end else begin
                    n_res.status = ST_OVERFLOW;
                end
            end
            S_RMW: begin
                n_res = '0;
                case (r_item.func)
                    FN_INSERT: begin
                        n_res.status        = ST_INSERTED;
                        n_res.bucket_id     = 12'(r_bkt);
                        n_res.prev_particle = r_last_rd.valid ? r_last_rd.idx : 12'd0;
                        n_res.prev_valid    = r_last_rd.valid;
                    end
                    FN_QBUCKET: begin
                        n_res.status    = ST_QDONE;
                        n_res.bucket_id = r_item.query_bucket;
                        if (qb_ok && r_first_rd.valid) begin
                            n_res.first_particle = r_first_rd.idx;
                            n_res.first_valid    = 1'b1;
                        end
                        if (qb_ok && r_last_rd.valid) begin
                            n_res.last_particle = r_last_rd.idx;
                            n_res.last_valid    = 1'b1;
                        end
                    end
                    default: begin
                        n_res.status = ST_QDONE;
                        if (pid_ok && r_next_rd.valid) begin
                            n_res.next_particle = r_next_rd.idx;
                            n_res.next_valid    = 1'b1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_data;
        if (r_state == S_OUT && out_free) r_out <= r_res;
        if (r_state == S_CALC) r_bkt <= calc_bucket;
        r_res <= n_res;
    end

    // table access: clearing pass or the insert's read-modify-write; reads also serve queries
    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.idx   = r_item.particle_id;

        bkt_raddr  = (r_item.func == FN_INSERT) ? r_bkt : BAW'(r_item.query_bucket);
        next_raddr = PAW'(r_item.particle_id);

        first_we    = 1'b0;
        last_we     = 1'b0;
        next_we     = 1'b0;
        first_waddr = r_bkt;
        last_waddr  = r_bkt;
        next_waddr  = PAW'(r_last_rd.idx);
        first_wdata = new_entry;
        last_wdata  = new_entry;
        next_wdata  = new_entry;

        if (r_state == S_CLR) begin
            first_we    = int'(r_clr_cnt) < MAX_BUCKETS;
            last_we     = first_we;
            next_we     = int'(r_clr_cnt) < MAX_PARTICLES;
            first_waddr = BAW'(r_clr_cnt);
            last_waddr  = BAW'(r_clr_cnt);
            next_waddr  = PAW'(r_clr_cnt);
            first_wdata = '0;
            last_wdata  = '0;
            next_wdata  = '0;
        end else if (r_state == S_RMW && r_item.func == FN_INSERT) begin
            last_we  = 1'b1;
            // append: link the old tail, or start the list
            next_we  = r_last_rd.valid;
            first_we = !r_last_rd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (first_we) mem_first[first_waddr] <= first_wdata;
        r_first_rd <= mem_first[bkt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (last_we) mem_last[last_waddr] <= last_wdata;
        r_last_rd <= mem_last[bkt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) mem_next[next_waddr] <= next_wdata;
        r_next_rd <= mem_next[next_raddr];
    end

endmodule

FILE: design/pclb_cell_calc.sv
// Bucket index pipeline: region test, reciprocal multiply, row offset, range check.
module pclb_cell_calc #(
    parameter int MAX_BUCKETS = 4096,
    parameter int BW          = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  pclb_pkg::t_cfg             i_cfg,
    output pclb_pkg::t_calc_flags      o_flags,
    output logic [BW-1:0]              o_bucket
);
    import pclb_pkg::*;

    localparam int PW = BW + 13;
    localparam int SW = BW + 14;

    // stage 0
    logic        r_v0, r_out0;
    logic [31:0] r_dx, r_dy;
    // stage 1
    logic        r_v1, r_out1;
    logic [63:0] r_px, r_py;
    // stage 2
    logic          r_v2, r_out2, r_ovf2;
    logic [BW-1:0] r_ix;
    logic [PW-1:0] r_iyt;
    // stage 3
    logic          r_v3, r_out3, r_ovf3;
    logic [BW-1:0] r_bkt;

    logic          outside;
    logic [31:0]   hi_x, hi_y;
    logic [BW-1:0] iy;
    logic [SW-1:0] sum;

    assign outside = (i_pos_x > i_cfg.max_x) || (i_pos_x < i_cfg.min_x) ||
                     (i_pos_y > i_cfg.max_y) || (i_pos_y < i_cfg.min_y);
    assign hi_x = r_px[63:32];
    assign hi_y = r_py[63:32];
    assign iy   = BW'(hi_y) + BW'(1);
    assign sum  = SW'(r_ix) + SW'(r_iyt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_go;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // difference is exact mod 2^32 whenever the point lies inside
        r_dx   <= 32'(i_pos_x - i_cfg.min_x);
        r_dy   <= 32'(i_pos_y - i_cfg.min_y);
        r_out0 <= outside;

        r_px   <= 64'(r_dx) * 64'(i_cfg.inv_len);
        r_py   <= 64'(r_dy) * 64'(i_cfg.inv_len);
        r_out1 <= r_out0;

        // cell = floor + 1; a floor of MAX_BUCKETS-1 or more can never fit
        r_ix   <= BW'(hi_x) + BW'(1);
        r_ovf2 <= (hi_x >= 32'(MAX_BUCKETS - 1)) ||
                  ((i_cfg.bpr != 13'd0) && (hi_y >= 32'(MAX_BUCKETS - 1)));
        r_iyt  <= (i_cfg.bpr == 13'd0) ? '0 : PW'(iy) * PW'(i_cfg.bpr);
        r_out2 <= r_out1;

        r_ovf3 <= r_ovf2 || (sum >= SW'(MAX_BUCKETS));
        r_bkt  <= BW'(sum);
        r_out3 <= r_out2;
    end

    assign o_flags.done     = r_v3;
    assign o_flags.outside  = r_out3;
    assign o_flags.overflow = r_ovf3;
    assign o_bucket         = r_bkt;

endmodule

FILE: design/pclb_checker.sv
// Port-level checks for the cell list builder, bound to the top level.
module pclb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pclb_pkg::t_result o_out_data
);
    import pclb_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // one word in flight: accept closes the input side
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous word still busy");

    // query fields are only set by query results
    a_query_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_QDONE) |->
            !o_out_data.first_valid && !o_out_data.last_valid && !o_out_data.next_valid)
        else $error("link fields set on non-query result");

    // rejected inserts and clears report no bucket and no predecessor
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_OUTSIDE || o_out_data.status == ST_OVERFLOW ||
                        o_out_data.status == ST_CLEARED) |->
            (o_out_data.bucket_id == 12'd0) && !o_out_data.prev_valid)
        else $error("rejected word carries bucket or predecessor");

endmodule

bind particle_cell_list_builder_core pclb_checker u_pclb_checker (.*);
